// ===== design/priority_deadline_task_scheduler_assert.svh =====
// Assertion macros for the priority deadline task scheduler.
// Expects clk and arst_n in scope where used.
`ifndef PRIORITY_DEADLINE_TASK_SCHEDULER_ASSERT_SVH
`define PRIORITY_DEADLINE_TASK_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define PDTS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PDTS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pdts_pkg.sv =====
// Shared types and constants for the priority deadline task scheduler.
// No dependencies.
package pdts_pkg;

	localparam int TASK_SLOTS = 32;
	localparam int SLOT_AW    = $clog2(TASK_SLOTS);
	localparam int ID_W       = 16;
	localparam int TIME_W     = 31;
	localparam int SLACK_W    = 32;
	localparam int FUNC_W     = 3;

	localparam logic [SLOT_AW-1:0] SLOT_LAST = SLOT_AW'(TASK_SLOTS - 1);

	localparam logic [FUNC_W-1:0] FN_TICK   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_ARRIVE = 3'd1;
	localparam logic [FUNC_W-1:0] FN_FINISH = 3'd2;
	localparam logic [FUNC_W-1:0] FN_IOREQ  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_IOEND  = 3'd4;
	localparam logic [FUNC_W-1:0] FN_SCHED  = 3'd5;

	typedef struct packed {
		logic               load;
		logic               rd;
		logic [SLOT_AW-1:0] rd_addr;
		logic               apply;
	} pdts_cmd_t;

	typedef struct packed {
		logic is_sched;
		logic out_busy;
	} pdts_stat_t;

endpackage

// ===== design/pdts_if.sv =====
// Handshake channels of the scheduler: event input and schedule result.
// Depends on pdts_pkg for field widths.
interface pdts_in_if;
	logic                          valid;
	logic                          ready;
	logic [pdts_pkg::FUNC_W-1:0]   func;
	logic [pdts_pkg::ID_W-1:0]     task_id;
	logic                          high_priority;
	logic [pdts_pkg::TIME_W-1:0]   deadline;
	logic [pdts_pkg::TIME_W-1:0]   arrival_time;
	logic [pdts_pkg::ID_W-1:0]     io_owner;

	modport source (output valid, func, task_id, high_priority, deadline, arrival_time,
		io_owner, input ready);
	modport sink (input valid, func, task_id, high_priority, deadline, arrival_time,
		io_owner, output ready);
endinterface

interface pdts_out_if;
	logic                      valid;
	logic                      ready;
	logic [pdts_pkg::ID_W-1:0] cpu_task;
	logic [pdts_pkg::ID_W-1:0] io_task;

	modport source (output valid, cpu_task, io_task, input ready);
	modport sink (input valid, cpu_task, io_task, output ready);
endinterface

// ===== design/priority_deadline_task_scheduler.sv =====
// Priority deadline task scheduler: top level joining controller and datapath.
// Depends on pdts_pkg, pdts_if, pdts_ctrl, pdts_dpath and the assertion header.
//
// Usage:
//   evt carries one event transaction: tick, arrival, finish, io request,
//   io end or schedule, with the task fields. res carries one transaction
//   (cpu_task, io_task) for each schedule event and nothing for the others.
//   Each event scans the whole task table through the single read port of
//   the table memory, one slot per cycle. An event occupies the block
//   through the accept, one read for each of the TASK_SLOTS slots, the
//   drain of the last read and the update; the update of a schedule event
//   writes its result to the result register. evt.ready is high only between events.
//   Reset empties the table and clears the io-ended mark; no result is held.
//   A waiting result does not block the next event; only the update of a
//   later schedule event waits until the receiver has taken the earlier one.
`include "priority_deadline_task_scheduler_assert.svh"

module priority_deadline_task_scheduler (
	input logic        clk,
	input logic        arst_n,
	pdts_in_if.sink    evt,
	pdts_out_if.source res
);
	import pdts_pkg::*;

	pdts_cmd_t  cmd;
	pdts_stat_t stat;

	pdts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (evt.valid),
		.in_ready (evt.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pdts_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.func          (evt.func),
		.task_id       (evt.task_id),
		.high_priority (evt.high_priority),
		.deadline      (evt.deadline),
		.arrival_time  (evt.arrival_time),
		.io_owner      (evt.io_owner),
		.res_ready     (res.ready),
		.res_valid     (res.valid),
		.cpu_task      (res.cpu_task),
		.io_task       (res.io_task)
	);

	`PDTS_ASSERT_NXT(a_busy_after_accept, evt.valid && evt.ready, !evt.ready, "event accepted while busy")
	`PDTS_ASSERT_IMP(a_no_overwrite, cmd.apply, !(stat.is_sched && stat.out_busy), "result overwritten")
	`PDTS_ASSERT_NXT(a_res_from_sched, cmd.apply && !stat.is_sched && !res.valid, !res.valid, "spurious result")

endmodule

// ===== design/pdts_ctrl.sv =====
// Controller of the scheduler: sequences accept, table scan and update.
// Depends on pdts_pkg.
module pdts_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pdts_pkg::pdts_stat_t stat,
	output pdts_pkg::pdts_cmd_t  cmd
);
	import pdts_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_APPLY = 2'd3;

	logic [1:0]         state_q, state_d;
	logic [SLOT_AW-1:0] cnt_q, cnt_d;
	logic               apply_ok;

	assign apply_ok = !(stat.is_sched && stat.out_busy);
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd.load    = 1'b0;
		cmd.rd      = 1'b0;
		cmd.rd_addr = cnt_q;
		cmd.apply   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd = 1'b1;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == SLOT_LAST) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last slot is still in the read stage
				state_d = ST_APPLY;
			end
			ST_APPLY: begin
				if (apply_ok) begin
					cmd.apply = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ===== design/pdts_dpath.sv =====
// Datapath of the scheduler: task table, scan accumulators, result register.
// Depends on pdts_pkg; driven by pdts_ctrl commands.
module pdts_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pdts_pkg::pdts_cmd_t           cmd,
	output pdts_pkg::pdts_stat_t          stat,
	input  logic [pdts_pkg::FUNC_W-1:0]   func,
	input  logic [pdts_pkg::ID_W-1:0]     task_id,
	input  logic                          high_priority,
	input  logic [pdts_pkg::TIME_W-1:0]   deadline,
	input  logic [pdts_pkg::TIME_W-1:0]   arrival_time,
	input  logic [pdts_pkg::ID_W-1:0]     io_owner,
	input  logic                          res_ready,
	output logic                          res_valid,
	output logic [pdts_pkg::ID_W-1:0]     cpu_task,
	output logic [pdts_pkg::ID_W-1:0]     io_task
);
	import pdts_pkg::*;

	function automatic logic ranks_before(input logic ha, input logic [SLACK_W-1:0] sa,
		input logic hb, input logic [SLACK_W-1:0] sb);
		return (ha && !hb) || ((ha == hb) && ($signed(sa) < $signed(sb)));
	endfunction

	// task table
	logic [ID_W-1:0]    task_mem  [TASK_SLOTS];
	logic [SLACK_W-1:0] slack_mem [TASK_SLOTS];
	logic [TASK_SLOTS-1:0] valid_q, high_q, inio_q;
	logic               io_ended_q;

	// captured item
	logic [FUNC_W-1:0]  func_q;
	logic [ID_W-1:0]    id_q, cur_io_q;
	logic               high_in_q;
	logic [SLACK_W-1:0] slack_in_q;

	// read stage
	logic               rd_s1;
	logic [SLOT_AW-1:0] idx_s1;
	logic [ID_W-1:0]    task_s1;
	logic [SLACK_W-1:0] slack_s1;

	// scan accumulators
	logic               free_fnd_q, id_fnd_q, cpu_fnd_q, io_fnd_q;
	logic [SLOT_AW-1:0] free_idx_q, id_idx_q, cpu_idx_q;
	logic               cpu_high_q, io_high_q;
	logic [SLACK_W-1:0] cpu_slack_q, io_slack_q;
	logic [ID_W-1:0]    cpu_task_q, io_task_q;

	logic               res_valid_q;
	logic [ID_W-1:0]    res_cpu_q, res_io_q;

	logic               v_s1, h_s1, io_s1;
	logic [ID_W-1:0]    io_hold;
	logic               do_arrive;

	assign v_s1  = valid_q[idx_s1];
	assign h_s1  = high_q[idx_s1];
	assign io_s1 = inio_q[idx_s1];

	assign io_hold   = io_ended_q ? '0 : cur_io_q;
	assign do_arrive = cmd.apply && (func_q == FN_ARRIVE) && free_fnd_q;

	assign stat.is_sched = (func_q == FN_SCHED);
	assign stat.out_busy = res_valid_q && !res_ready;

	assign res_valid = res_valid_q;
	assign cpu_task  = res_cpu_q;
	assign io_task   = res_io_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q     <= func;
			id_q       <= task_id;
			cur_io_q   <= io_owner;
			high_in_q  <= high_priority;
			slack_in_q <= {1'b0, deadline} - {1'b0, arrival_time};
		end
	end

	// table memory: one write port at apply, one registered read port for the scan
	always_ff @(posedge clk) begin
		if (do_arrive) begin
			task_mem[free_idx_q]  <= id_q;
			slack_mem[free_idx_q] <= slack_in_q;
		end
		if (cmd.rd) begin
			task_s1  <= task_mem[cmd.rd_addr];
			slack_s1 <= slack_mem[cmd.rd_addr];
		end
		idx_s1 <= cmd.rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd;
		end
	end

	// per-slot flags without reset value
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			case (func_q)
				FN_ARRIVE: begin
					if (free_fnd_q) begin
						high_q[free_idx_q] <= high_in_q;
						inio_q[free_idx_q] <= 1'b0;
					end
				end
				FN_IOREQ: begin
					if (id_fnd_q) begin
						inio_q[id_idx_q] <= 1'b1;
					end
				end
				FN_IOEND: begin
					if (id_fnd_q) begin
						inio_q[id_idx_q] <= 1'b0;
					end
				end
				FN_SCHED: begin
					if (cpu_fnd_q) begin
						high_q[cpu_idx_q] <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			io_ended_q <= 1'b0;
		end else if (cmd.apply) begin
			case (func_q)
				FN_ARRIVE: begin
					if (free_fnd_q) begin
						valid_q[free_idx_q] <= 1'b1;
					end
				end
				FN_FINISH: begin
					if (id_fnd_q) begin
						valid_q[id_idx_q] <= 1'b0;
					end
				end
				FN_IOEND: begin
					io_ended_q <= 1'b1;
				end
				FN_SCHED: begin
					io_ended_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// scan: lowest free slot, lowest slot with the id, best runnable, best io-waiting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_fnd_q <= 1'b0;
			id_fnd_q   <= 1'b0;
			cpu_fnd_q  <= 1'b0;
			io_fnd_q   <= 1'b0;
		end else if (cmd.load) begin
			free_fnd_q <= 1'b0;
			id_fnd_q   <= 1'b0;
			cpu_fnd_q  <= 1'b0;
			io_fnd_q   <= 1'b0;
		end else if (rd_s1) begin
			if (!v_s1 && !free_fnd_q) begin
				free_fnd_q <= 1'b1;
			end
			if (v_s1 && (task_s1 == id_q) && !id_fnd_q) begin
				id_fnd_q <= 1'b1;
			end
			if (v_s1 && !io_s1 &&
				(!cpu_fnd_q || ranks_before(h_s1, slack_s1, cpu_high_q, cpu_slack_q))) begin
				cpu_fnd_q <= 1'b1;
			end
			if (v_s1 && io_s1 &&
				(!io_fnd_q || ranks_before(h_s1, slack_s1, io_high_q, io_slack_q))) begin
				io_fnd_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1) begin
			if (!v_s1 && !free_fnd_q) begin
				free_idx_q <= idx_s1;
			end
			if (v_s1 && (task_s1 == id_q) && !id_fnd_q) begin
				id_idx_q <= idx_s1;
			end
			if (v_s1 && !io_s1 &&
				(!cpu_fnd_q || ranks_before(h_s1, slack_s1, cpu_high_q, cpu_slack_q))) begin
				cpu_idx_q   <= idx_s1;
				cpu_high_q  <= h_s1;
				cpu_slack_q <= slack_s1;
				cpu_task_q  <= task_s1;
			end
			if (v_s1 && io_s1 &&
				(!io_fnd_q || ranks_before(h_s1, slack_s1, io_high_q, io_slack_q))) begin
				io_high_q  <= h_s1;
				io_slack_q <= slack_s1;
				io_task_q  <= task_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.apply && (func_q == FN_SCHED)) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && (func_q == FN_SCHED)) begin
			res_cpu_q <= cpu_fnd_q ? cpu_task_q : '0;
			res_io_q  <= ((io_hold == '0) && io_fnd_q) ? io_task_q : io_hold;
		end
	end

endmodule
